// ===== src/btp_pkg.sv =====
// ----------------------------------------------------------------------------
// btp_pkg
// Shared types and constants for the binary tile packer.
// ----------------------------------------------------------------------------
`default_nettype none

package btp_pkg;

    // Tile geometry is fixed at 4x4 pixels, 16 bits per tile word
    localparam int TILE_SIZE    = 4;
    localparam int TILE_BITS    = TILE_SIZE * TILE_SIZE;
    localparam int TILE_SHIFT   = 2;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int MAX_HEIGHT    = 4096;

    // Configuration register fields
    localparam int CFG_WIDTH_W  = 11;
    localparam int CFG_HEIGHT_W = 13;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_INDEX_W  = 1;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET  = 11'd1024;
    localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET = 13'd4096;

    // Pixel row counter and output field widths
    localparam int ROW_W      = 12;
    localparam int TILE_ROW_W = 10;
    localparam int TILE_COL_W = 8;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 40;

    // Result buffer depth: one slot draining, one in flight, one spare
    localparam int OUT_DEPTH = 3;

    typedef struct packed {
        logic                  last_tile;
        logic [TILE_COL_W-1:0] tile_col;
        logic [TILE_ROW_W-1:0] tile_row;
        logic [TILE_BITS-1:0]  tile_word;
    } result_t;

endpackage

`default_nettype wire

// ===== src/btp_tile_store.sv =====
// ----------------------------------------------------------------------------
// btp_tile_store
// Partial tile words for one band of rows: one write port, one registered
// read port.
// ----------------------------------------------------------------------------
`default_nettype none

module btp_tile_store
    import btp_pkg::*;
#(
    parameter int DEPTH = MAX_WIDTH_DEF / TILE_SIZE,
    parameter int IDX_W = 8
) (
    input  wire logic                 aclk,
    input  wire logic                 rd_en,
    input  wire logic [IDX_W-1:0]     rd_addr,
    output logic      [TILE_BITS-1:0] rd_data,
    input  wire logic                 wr_en,
    input  wire logic [IDX_W-1:0]     wr_addr,
    input  wire logic [TILE_BITS-1:0] wr_data
);

    logic [TILE_BITS-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== src/btp_out_fifo.sv =====
// ----------------------------------------------------------------------------
// btp_out_fifo
// Small result buffer that parts the tile pipeline from the output stream.
// ----------------------------------------------------------------------------
`default_nettype none

module btp_out_fifo
    import btp_pkg::*;
#(
    parameter int DEPTH = OUT_DEPTH
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       push,
    input  wire result_t                    push_data,
    input  wire logic                       pop,
    output result_t                         head,
    output logic                            not_empty,
    output logic [$clog2(DEPTH+1)-1:0]      count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    result_t            slots [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg,  count_next;
    logic               do_pop;

    assign do_pop = pop && (count_reg != '0);

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots[wr_ptr_reg] <= push_data;
        end
    end

    assign head      = slots[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign count     = count_reg;

endmodule

`default_nettype wire

// ===== src/binary_tile_packer_4x4.sv =====
// ----------------------------------------------------------------------------
// binary_tile_packer_4x4
// Binarizes raster-order RGBA pixels and packs them into 16-bit 4x4 tile words.
// ----------------------------------------------------------------------------
// Throughput: one pixel per clock, set by the single read-modify-write pass of
//   the tile store; input stalls only while buffer count plus stage 1 valid reaches 3.
// Output path: the tile's last pixel passes the stage 1 registers and is then
//   pushed into the result buffer, whose not-empty flag drives m_tvalid.
// Reset: clears the pixel counters and the result buffer, loads 1024 x 4096;
//   the tile store is not cleared, each word restarts on its tile's first pixel.
`default_nettype none

module binary_tile_packer_4x4
    import btp_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,

    // Pixel input stream
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire logic [IN_DATA_W-1:0]    s_tdata,   // red[7:0], green[15:8], blue[23:16],
                                                    // alpha[31:24]

    // Tile result stream
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    output logic [OUT_DATA_W-1:0]        m_tdata,   // tile_word[15:0], tile_row[25:16],
                                                    // tile_col[33:26], zero pad[39:34]
    output logic                         m_tlast,   // last_tile

    // Configuration write channel
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   cfg_data
);

    // ------------------------------------------------------------------
    // Derived sizes
    // ------------------------------------------------------------------
    localparam int CNT_W     = $clog2(MAX_WIDTH);
    localparam int LW        = ((CNT_W + 1) > CFG_WIDTH_W) ? (CNT_W + 1) : CFG_WIDTH_W;
    localparam int XPW       = (CNT_W > TILE_COL_W + TILE_SHIFT) ? CNT_W
                                                                 : (TILE_COL_W + TILE_SHIFT);
    localparam int TILE_COLS = MAX_WIDTH / TILE_SIZE;
    localparam int IDX_W     = (TILE_COLS > 1) ? $clog2(TILE_COLS) : 1;
    localparam int FCNT_W    = $clog2(OUT_DEPTH + 1);

    // ------------------------------------------------------------------
    // Configuration registers, always ready; not enforced here, the user must write them only while idle
    // ------------------------------------------------------------------
    logic [CFG_WIDTH_W-1:0]  image_width_reg;
    logic [CFG_HEIGHT_W-1:0] image_height_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= WIDTH_RESET;
            image_height_reg <= HEIGHT_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[CFG_WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data[CFG_HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp the registers: zero acts as one, oversize acts as the maximum
    logic [LW-1:0]           width_ext, width_eff;
    logic [CFG_HEIGHT_W-1:0] height_eff;

    assign width_ext = LW'(image_width_reg);

    always_comb begin
        if (width_ext == '0) begin
            width_eff = LW'(1);
        end else if (width_ext > LW'(MAX_WIDTH)) begin
            width_eff = LW'(MAX_WIDTH);
        end else begin
            width_eff = width_ext;
        end
        if (image_height_reg == '0) begin
            height_eff = CFG_HEIGHT_W'(1);
        end else if (image_height_reg > CFG_HEIGHT_W'(MAX_HEIGHT)) begin
            height_eff = CFG_HEIGHT_W'(MAX_HEIGHT);
        end else begin
            height_eff = image_height_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: position counters, tile store read
    // ------------------------------------------------------------------
    logic [CNT_W-1:0] col_count_reg, col_count_next;
    logic [ROW_W-1:0] row_count_reg, row_count_next;
    logic             s_accept;
    logic             pixel_set;
    logic             row_end, last_row, col_end, band_end;
    logic [1:0]       tx, ty;
    logic [CNT_W-1:0] tile_x;
    logic [IDX_W-1:0] rd_idx;
    logic [XPW-1:0]   x_ext;

    assign s_accept  = s_tvalid && s_tready;
    assign pixel_set = (s_tdata != '0);
    assign tx        = col_count_reg[1:0];
    assign ty        = row_count_reg[1:0];
    assign row_end   = ((LW'(col_count_reg) + LW'(1)) >= width_eff);
    assign last_row  = ((CFG_HEIGHT_W'(row_count_reg) + CFG_HEIGHT_W'(1)) >= height_eff);
    assign col_end   = row_end || (tx == 2'(TILE_SIZE - 1));
    assign band_end  = last_row || (ty == 2'(TILE_SIZE - 1));
    assign tile_x    = col_count_reg >> TILE_SHIFT;
    assign x_ext     = XPW'(col_count_reg);

    // Wrap the tile column into the store depth
    always_comb begin
        if (tile_x >= CNT_W'(TILE_COLS)) begin
            rd_idx = IDX_W'(tile_x - CNT_W'(TILE_COLS));
        end else begin
            rd_idx = IDX_W'(tile_x);
        end
    end

    // Advance along the row, wrap at row end and at image end
    always_comb begin
        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        if (s_accept) begin
            if (row_end) begin
                col_count_next = '0;
                row_count_next = last_row ? '0 : row_count_reg + 1'b1;
            end else begin
                col_count_next = col_count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_count_reg <= '0;
            row_count_reg <= '0;
        end else begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1 registers: pixel info waiting for the store read data
    // ------------------------------------------------------------------
    logic                 s1_valid_reg;
    logic [IDX_W-1:0]     s1_idx_reg;
    logic                 s1_first_reg;
    logic                 s1_set_reg;
    logic [3:0]           s1_bit_reg;
    logic                 s1_emit_reg;
    logic                 s1_fwd_reg;
    logic [TILE_ROW_W-1:0] s1_row_reg;
    logic [TILE_COL_W-1:0] s1_col_reg;
    logic                 s1_last_reg;
    logic [TILE_BITS-1:0] last_word_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s_accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_idx_reg   <= rd_idx;
            s1_first_reg <= (tx == 2'd0) && (ty == 2'd0);
            s1_set_reg   <= pixel_set;
            // Bit 15 is top-left: position 15 - (4*ty + tx)
            s1_bit_reg   <= {~ty, ~tx};
            s1_emit_reg  <= col_end && band_end;
            // Forward when the previous pixel writes this entry at this edge
            s1_fwd_reg   <= s1_valid_reg && (s1_idx_reg == rd_idx);
            s1_row_reg   <= row_count_reg[ROW_W-1:TILE_SHIFT];
            s1_col_reg   <= x_ext[TILE_COL_W+TILE_SHIFT-1:TILE_SHIFT];
            s1_last_reg  <= row_end && last_row;
        end
    end

    // ------------------------------------------------------------------
    // Tile store: read at accept, merge and write back in stage 1
    // ------------------------------------------------------------------
    logic [TILE_BITS-1:0] rd_data;
    logic [TILE_BITS-1:0] base_word, merged_word;

    btp_tile_store #(
        .DEPTH (TILE_COLS),
        .IDX_W (IDX_W)
    ) u_store (
        .aclk    (aclk),
        .rd_en   (s_accept),
        .rd_addr (rd_idx),
        .rd_data (rd_data),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_idx_reg),
        .wr_data (merged_word)
    );

    always_comb begin
        if (s1_first_reg) begin
            base_word = '0;
        end else if (s1_fwd_reg) begin
            base_word = last_word_reg;
        end else begin
            base_word = rd_data;
        end
        merged_word = base_word;
        if (s1_set_reg) begin
            merged_word[s1_bit_reg] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_valid_reg) begin
            last_word_reg <= merged_word;
        end
    end

    // ------------------------------------------------------------------
    // Result buffer
    // ------------------------------------------------------------------
    result_t             push_data, head;
    logic                fifo_push;
    logic                fifo_not_empty;
    logic [FCNT_W-1:0]   fifo_count;

    assign fifo_push = s1_valid_reg && s1_emit_reg;

    always_comb begin
        push_data.tile_word = (merged_word != '0) ? merged_word : TILE_BITS'(1);
        push_data.tile_row  = s1_row_reg;
        push_data.tile_col  = s1_col_reg;
        push_data.last_tile = s1_last_reg;
    end

    btp_out_fifo #(
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (fifo_push),
        .push_data (push_data),
        .pop       (m_tready),
        .head      (head),
        .not_empty (fifo_not_empty),
        .count     (fifo_count)
    );

    // Hold input while the buffer cannot take both the stage 1 item and a new one
    assign s_tready = ((FCNT_W + 1)'(fifo_count) + (FCNT_W + 1)'(s1_valid_reg))
                      < (FCNT_W + 1)'(OUT_DEPTH);

    assign m_tvalid = fifo_not_empty;
    assign m_tdata  = {(OUT_DATA_W - TILE_BITS - TILE_ROW_W - TILE_COL_W)'(0),
                       head.tile_col, head.tile_row, head.tile_word};
    assign m_tlast  = head.last_tile;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Buffer never takes a result when full, unless a result is popped in the same cycle
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(fifo_push && (fifo_count == FCNT_W'(OUT_DEPTH)) && !m_tready))
        else $error("result buffer overflow");

    // Last pixel of the image returns both counters to the origin
    a_image_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && row_end && last_row) |=> (col_count_reg == '0 && row_count_reg == '0))
        else $error("counters did not wrap at image end");

    // A back-to-back write to the same entry always sets forwarding
    a_fwd_source: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s1_valid_reg && (s1_idx_reg == rd_idx)) |=> s1_fwd_reg)
        else $error("missed forwarding of in-flight tile word");

endmodule

`default_nettype wire

// ===== tb/tb_binary_tile_packer_4x4.sv =====
// ----------------------------------------------------------------------------
// tb_binary_tile_packer_4x4
// Self-checking testbench for the 4x4 binary tile packer.
// ----------------------------------------------------------------------------
// Pixels go in on the s_ stream and are mirrored by a predictor that keeps its
// own band store and pixel counters. Each pixel that carries a tile's last
// pixel queues the expected tile. A monitor pops one expectation per accepted
// tile on the m_ stream and compares word, row, column and last flag. Sizes
// are reprogrammed between images (and, where the store stays coherent, in
// the middle of one). Both streams idle at random, except for one steady run.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_binary_tile_packer_4x4;
    import btp_pkg::*;

    // Idle cycles let past the last expected tile: the result path runs through
    // stage 1 and the result buffer, leave margin for the output buffer.
    localparam int SETTLE_CYCLES = 8;
    // Cycles without any transaction before the run is declared hung
    localparam int QUIET_LIMIT   = 2000;
    localparam int RANDOM_PIXELS = 650;
    localparam int STEADY_PIXELS = 250;
    localparam int IDLE_PERCENT  = 24;
    localparam int STORE_SLOTS   = MAX_WIDTH_DEF / TILE_SIZE;

    // Pixel as it sits in s_tdata, red in the lowest byte
    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_t;

    logic                    aclk      = 1'b0;
    logic                    aresetn   = 1'b0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    logic [IN_DATA_W-1:0]    s_tdata   = '0;
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0]   m_tdata;
    logic                    m_tlast;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_INDEX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data  = '0;

    binary_tile_packer_4x4 u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Predictor state: size registers, band store and pixel position
    // ------------------------------------------------------------------
    logic [CFG_WIDTH_W-1:0]  reg_width  = WIDTH_RESET;
    logic [CFG_HEIGHT_W-1:0] reg_height = HEIGHT_RESET;
    logic [TILE_BITS-1:0]    band_words [STORE_SLOTS];
    int unsigned             col_pos = 0;
    int unsigned             row_pos = 0;

    result_t     pending_tiles [$];
    int unsigned mismatch_count = 0;
    int unsigned pixels_sent    = 0;
    int unsigned quiet_cycles   = 0;
    bit          steady_flow    = 1'b0;

    // Corner values: blank, each channel saturated alone, all set, lowest and
    // highest bit of each channel alone, a blank pad and a mid-range pixel.
    // Sixteen of them fill one 4x4 tile at a width of 4.
    logic [IN_DATA_W-1:0] corner_pixels [16] = '{
        32'h0000_0000, 32'h0000_00FF, 32'h0000_FF00, 32'h00FF_0000,
        32'hFF00_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0100,
        32'h0001_0000, 32'h0100_0000, 32'h0000_0080, 32'h0000_8000,
        32'h0080_0000, 32'h8000_0000, 32'h0000_0000, 32'h7F7F_7F7F
    };

    // Advance the predictor by one accepted pixel; queue a tile when the
    // pixel closes one (right edge of the tile or image, bottom of the band
    // or image).
    task automatic pack_pixel(input pixel_t px);
        int unsigned          eff_w;
        int unsigned          eff_h;
        int unsigned          tx;
        int unsigned          ty;
        int unsigned          slot;
        logic [TILE_BITS-1:0] word;
        logic                 row_end;
        logic                 last_row;
        result_t              tile;
        eff_w = (reg_width == 0) ? 1 :
                (reg_width > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(reg_width);
        eff_h = (reg_height == 0) ? 1 :
                (reg_height > MAX_HEIGHT) ? MAX_HEIGHT : int'(reg_height);
        tx   = col_pos % TILE_SIZE;
        ty   = row_pos % TILE_SIZE;
        slot = (col_pos / TILE_SIZE) % STORE_SLOTS;

        // Restart the word on the tile's top-left pixel
        word = (tx == 0 && ty == 0) ? '0 : band_words[slot];
        if (px != '0)
            word[TILE_BITS - 1 - (ty * TILE_SIZE + tx)] = 1'b1;
        band_words[slot] = word;

        row_end  = (col_pos + 1 >= eff_w);
        last_row = (row_pos + 1 >= eff_h);
        if ((row_end || tx == TILE_SIZE - 1) && (last_row || ty == TILE_SIZE - 1)) begin
            // An all-blank tile is reported as 1, never as 0
            tile.tile_word = (word == '0) ? TILE_BITS'(1) : word;
            tile.tile_row  = TILE_ROW_W'(row_pos / TILE_SIZE);
            tile.tile_col  = TILE_COL_W'(col_pos / TILE_SIZE);
            tile.last_tile = row_end && last_row;
            pending_tiles = {pending_tiles, tile};
        end

        if (row_end) begin
            col_pos = 0;
            row_pos = last_row ? 0 : row_pos + 1;
        end else begin
            col_pos = col_pos + 1;
        end
    endtask

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("MISMATCH %s: got 0x%0h, expected 0x%0h (t=%0t)", what, got, want, $time);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Result side: random back-pressure, steady during the steady run
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        m_tready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    // Check every accepted tile against the oldest expectation
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_tiles.size() == 0) begin
                report_mismatch("tile with nothing expected", m_tdata[15:0], 0);
            end else begin
                want = pending_tiles.pop_front();
                if (m_tdata[15:0] != want.tile_word)
                    report_mismatch("tile_word", m_tdata[15:0], want.tile_word);
                if (m_tdata[25:16] != want.tile_row)
                    report_mismatch("tile_row", m_tdata[25:16], want.tile_row);
                if (m_tdata[33:26] != want.tile_col)
                    report_mismatch("tile_col", m_tdata[33:26], want.tile_col);
                if (m_tlast != want.last_tile)
                    report_mismatch("last_tile", m_tlast, want.last_tile);
            end
        end
    end

    // Watchdog: end the run when no transaction moves for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Blank pixels, single-channel pixels and, most often, random mixes with
    // some channels zeroed, so tiles come out sparse, dense and empty.
    function automatic pixel_t random_pixel();
        pixel_t      px;
        int unsigned pick;
        px   = '0;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            px = '0;
        end else if (pick < 50) begin
            case ($urandom_range(0, 3))
                0: px.red   = 8'($urandom_range(1, 255));
                1: px.green = 8'($urandom_range(1, 255));
                2: px.blue  = 8'($urandom_range(1, 255));
                default: px.alpha = 8'($urandom_range(1, 255));
            endcase
        end else begin
            px.red   = ($urandom_range(0, 9) < 3) ? 8'd0 : 8'($urandom_range(0, 255));
            px.green = ($urandom_range(0, 9) < 3) ? 8'd0 : 8'($urandom_range(0, 255));
            px.blue  = ($urandom_range(0, 9) < 3) ? 8'd0 : 8'($urandom_range(0, 255));
            px.alpha = ($urandom_range(0, 9) < 3) ? 8'd0 : 8'($urandom_range(0, 255));
        end
        return px;
    endfunction

    // Send one pixel. Valid stays high after the transaction so that
    // back-to-back pixels never drop it; whoever stops sending lowers it.
    task automatic send_pixel(input pixel_t px);
        while (!steady_flow && $urandom_range(0, 99) < IDLE_PERCENT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        do @(posedge aclk); while (!s_tready);
        pack_pixel(px);
        pixels_sent++;
    endtask

    task automatic send_pixels(input int unsigned count);
        repeat (count) send_pixel(random_pixel());
    endtask

    // Send random pixels until the image wraps back to its first pixel
    task automatic finish_image();
        do send_pixel(random_pixel()); while (col_pos != 0 || row_pos != 0);
    endtask

    // Hold the pixel stream until every expected tile has come out, then
    // let the pipeline drain.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_tiles.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Register write; cfg_valid is left high for a following write
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        if (index == REG_IMAGE_WIDTH)
            reg_width = value[CFG_WIDTH_W-1:0];
        else
            reg_height = value;
    endtask

    // Drain, then program both size registers
    task automatic configure(input logic [CFG_DATA_W-1:0] width_val,
                             input logic [CFG_DATA_W-1:0] height_val);
        settle();
        write_reg(REG_IMAGE_WIDTH, width_val);
        write_reg(REG_IMAGE_HEIGHT, height_val);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset size: eight pixels of row 0 close no tile, since the row is
    // wider and the band still open. A width of 12 and a height of 1 then
    // land on the start of tile column 2, which closes as the last tile.
    task automatic test_reset_size();
        send_pixels(8);
        configure(12, 1);
        finish_image();
    endtask

    // Corner pixel values in one tile, then a blank row that must give 1.
    // The height change lands on a band start, so the store stays coherent.
    task automatic test_pixel_values();
        configure(4, 8);
        foreach (corner_pixels[i]) send_pixel(pixel_t'(corner_pixels[i]));
        configure(4, 1);
        repeat (4) send_pixel('0);
    endtask

    // Sizes that are and are not multiples of 4, down to 1x1.
    task automatic test_edge_sizes();
        configure(1, 1);       finish_image();
        configure(4, 4);       finish_image();
        configure(5, 6);       finish_image();
        configure(3, 7);       finish_image();
        configure(2, 2);       finish_image();
        configure(7, 5);       finish_image();
        configure(8, 8);       finish_image();
        configure(13, 9);      finish_image();
    endtask

    // Out-of-range sizes: zero acts as 1, and width bits above the
    // register are dropped.
    task automatic test_register_limits();
        configure(0, 0);         finish_image();
        configure(13'h0805, 0);  finish_image();
        configure(0, 6);         finish_image();
        configure(13'h1803, 5);  finish_image();
    endtask

    // Size writes in the middle of an image: counters carry on
    task automatic test_mid_image_writes();
        // Shrink the height inside a band: the current row becomes the last
        configure(8, 12);
        send_pixels(8 * 5);
        configure(8, 6);
        finish_image();
        // Shrink the height below the current row
        configure(5, 20);
        send_pixels(5 * 9);
        configure(5, 3);
        finish_image();
        // Widen at a band start
        configure(8, 8);
        send_pixels(8 * 4);
        configure(12, 8);
        finish_image();
    endtask

    // Random sizes and pixels; mostly small images, now and then a wide one
    task automatic test_random_images();
        int unsigned start;
        int unsigned w_val;
        int unsigned h_val;
        start = pixels_sent;
        steady_flow = 1'b1;
        while (pixels_sent - start < RANDOM_PIXELS) begin
            if ($urandom_range(0, 9) == 0) begin
                w_val = $urandom_range(64, 256);
                h_val = $urandom_range(1, 2);
            end else begin
                w_val = $urandom_range(1, 24);
                h_val = $urandom_range(1, 12);
            end
            configure(CFG_DATA_W'(w_val), CFG_DATA_W'(h_val));
            repeat ($urandom_range(1, 2)) begin
                // Now and then pause mid-image until every tile is out
                if ($urandom_range(0, 5) == 0) begin
                    send_pixels($urandom_range(1, w_val));
                    settle();
                end
                finish_image();
                if (pixels_sent - start >= STEADY_PIXELS)
                    steady_flow = 1'b0;
            end
        end
        steady_flow = 1'b0;
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_size();
        test_pixel_values();
        test_edge_sizes();
        test_register_limits();
        test_mid_image_writes();
        test_random_images();

        settle();
        if (pending_tiles.size() != 0)
            report_mismatch("tiles never produced", 0, pending_tiles.size());

        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
src/btp_pkg.sv
src/btp_tile_store.sv
src/btp_out_fifo.sv
src/binary_tile_packer_4x4.sv
tb/tb_binary_tile_packer_4x4.sv
